// File: rtl/core/wlrs_pkg.sv
// Package for the wear-leveled record store.
// Shared constants, register indexes and the configuration struct.
// No dependencies.
`default_nettype none

package wlrs_pkg;

  localparam int DEF_STORE_BYTES      = 256;
  localparam int DEF_MAX_RECORD_BYTES = 32;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int SIZE_W     = 6;
  localparam int SLOTS_W    = 8;
  localparam int START_W    = 8;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SLOTS = 2'd2;

  localparam logic [START_W-1:0] RST_REGION_START = 8'd0;
  localparam logic [SIZE_W-1:0]  RST_RECORD_SIZE  = 6'd4;
  localparam logic [SLOTS_W-1:0] RST_RECORD_SLOTS = 8'd4;

  // action codes of an input item
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SAVE = 1'b1;

  localparam logic [BYTE_W-1:0] BYTE_ERASED = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_LOW7   = 8'h7F;

  // effective (clamped) configuration seen by the sequencer
  typedef struct packed {
    logic [START_W-1:0] region_start;
    logic [SIZE_W-1:0]  record_size;
    logic [SLOTS_W-1:0] record_slots;
  } wlrs_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/wlrs_if.sv
// Handshake channels of the wear-leveled record store.
// Depends on nothing; payload widths are fixed by the item fields.
`default_nettype none

interface wlrs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface wlrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       found;
  logic       saved;
  logic       last_of_run;

  modport source (output valid, output out_byte, output found, output saved,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input found, input saved,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wlrs_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module wlrs_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wlrs_ctrl.sv
// Sequencer of the wear-leveled record store: clear, scan, load, compare and copy.
// Drives the store and staging RAMs; uses wlrs_pkg and the wlrs_if channels.
`default_nettype none

module wlrs_ctrl #(
  parameter  int STORE_BYTES      = wlrs_pkg::DEF_STORE_BYTES,
  parameter  int MAX_RECORD_BYTES = wlrs_pkg::DEF_MAX_RECORD_BYTES,
  localparam int SAW = $clog2(STORE_BYTES),
  localparam int IW  = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire wlrs_pkg::wlrs_cfg_t cfg,
  wlrs_in_if.sink                 in_ch,
  wlrs_out_if.source              out_ch,
  // store RAM
  output logic                    st_we,
  output logic [SAW-1:0]          st_waddr,
  output logic [7:0]              st_wdata,
  output logic                    st_re,
  output logic [SAW-1:0]          st_raddr,
  input  wire logic [7:0]         st_rdata,
  // staging RAM
  output logic                    sg_we,
  output logic [IW-1:0]           sg_waddr,
  output logic [7:0]              sg_wdata,
  output logic                    sg_re,
  output logic [IW-1:0]           sg_raddr,
  input  wire logic [7:0]         sg_rdata
);

  // position arithmetic must hold start + size*slots and addr + 2*size
  localparam int PW = ((SAW > 14) ? SAW : 14) + 2;
  localparam int XW = (IW > wlrs_pkg::SIZE_W) ? IW : wlrs_pkg::SIZE_W;
  localparam logic [PW-1:0]  STORE_LIM = PW'(STORE_BYTES);
  localparam logic [SAW-1:0] CLR_LAST  = SAW'(STORE_BYTES - 1);

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_SETUP   = 14'b00000000000100,
    S_SCAN_RD = 14'b00000000001000,
    S_SCAN_WT = 14'b00000000010000,
    S_PICK    = 14'b00000000100000,
    S_CMP_RD  = 14'b00000001000000,
    S_CMP_WT  = 14'b00000010000000,
    S_MARK    = 14'b00000100000000,
    S_CP_RD   = 14'b00001000000000,
    S_CP_WT   = 14'b00010000000000,
    S_LD_RD   = 14'b00100000000000,
    S_LD_WT   = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic            op_save_r, op_save_nxt;
  logic            found_r, found_nxt;
  logic            saved_r, saved_nxt;
  logic [PW-1:0]   cur_r, cur_nxt;
  logic [PW-1:0]   start_r, start_nxt;
  logic [PW-1:0]   end_r, end_nxt;
  logic [wlrs_pkg::SIZE_W-1:0] sz_r, sz_nxt;
  logic [XW-1:0]   idx_r, idx_nxt;
  logic [XW-1:0]   cnt_r, cnt_nxt;
  logic [SAW-1:0]  clr_r, clr_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_found_r, out_found_nxt;
  logic            out_saved_r, out_saved_nxt;
  logic            out_last_r, out_last_nxt;

  logic            accept;
  logic            out_free;
  logic            load_out;
  logic [PW-1:0]   sz_ext;
  logic [PW-1:0]   next_a;
  logic [PW-1:0]   cur_idx;
  logic            fits_cur;
  logic            fits_start;
  logic            fits_next;
  logic            idx_last;
  logic [7:0]      old_b;
  logic [7:0]      new_b;
  logic [XW-1:0]   cnt_inc;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.saved       = out_saved_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_free           = !out_valid_r || out_ch.ready;

  assign sz_ext     = PW'(sz_r);
  assign next_a     = cur_r + sz_ext;
  assign cur_idx    = cur_r + PW'(idx_r);
  assign fits_cur   = (cur_r + sz_ext) <= STORE_LIM;
  assign fits_start = (start_r + sz_ext) <= STORE_LIM;
  assign fits_next  = (next_a + sz_ext) <= STORE_LIM;
  assign idx_last   = (idx_r + XW'(1)) == XW'(sz_r);
  assign cnt_inc    = cnt_r + XW'(1);
  // byte 0 is compared and written with its flag bit masked
  assign old_b      = (idx_r == '0) ? (st_rdata & wlrs_pkg::BYTE_LOW7) : st_rdata;
  assign new_b      = (idx_r == '0) ? (sg_rdata & wlrs_pkg::BYTE_LOW7) : sg_rdata;

  always_comb begin
    state_nxt     = state_r;
    op_save_nxt   = op_save_r;
    found_nxt     = found_r;
    saved_nxt     = saved_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    sz_nxt        = sz_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    load_out      = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_found_nxt = out_found_r;
    out_saved_nxt = out_saved_r;
    out_last_nxt  = out_last_r;
    st_we         = 1'b0;
    st_waddr      = SAW'(cur_idx);
    st_wdata      = new_b;
    st_re         = 1'b0;
    st_raddr      = SAW'(cur_idx);
    sg_we         = 1'b0;
    sg_waddr      = cnt_r[IW-1:0];
    sg_wdata      = in_ch.data_byte;
    sg_re         = 1'b0;
    sg_raddr      = idx_r[IW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = wlrs_pkg::BYTE_ERASED;
        clr_nxt  = clr_r + SAW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_ch.action == wlrs_pkg::ACT_SAVE) begin
            sg_we = 1'b1;
            if (cnt_inc >= XW'(cfg.record_size)) begin
              cnt_nxt     = '0;
              op_save_nxt = 1'b1;
              state_nxt   = S_SETUP;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end else begin
            op_save_nxt = 1'b0;
            state_nxt   = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        sz_nxt    = cfg.record_size;
        start_nxt = PW'(cfg.region_start);
        cur_nxt   = PW'(cfg.region_start);
        end_nxt   = PW'(cfg.region_start) + PW'(cfg.record_size) * PW'(cfg.record_slots);
        found_nxt = 1'b0;
        saved_nxt = 1'b0;
        idx_nxt   = '0;
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (cur_r < end_r && fits_cur) begin
          st_re     = 1'b1;
          st_raddr  = SAW'(cur_r);
          state_nxt = S_SCAN_WT;
        end else begin
          state_nxt = S_PICK;
        end
      end
      S_SCAN_WT: begin
        if (!st_rdata[7]) begin
          found_nxt = 1'b1;
          state_nxt = S_PICK;
        end else begin
          cur_nxt   = next_a;
          state_nxt = S_SCAN_RD;
        end
      end
      S_PICK: begin
        idx_nxt = '0;
        if (!op_save_r) begin
          state_nxt = found_r ? S_LD_RD : S_DONE;
        end else if (found_r) begin
          state_nxt = S_CMP_RD;
        end else begin
          // no current record: the first slot stands in as the old one
          cur_nxt   = start_r;
          state_nxt = fits_start ? S_CMP_RD : S_DONE;
        end
      end
      S_CMP_RD: begin
        st_re     = 1'b1;
        sg_re     = 1'b1;
        state_nxt = S_CMP_WT;
      end
      S_CMP_WT: begin
        if (old_b != new_b) begin
          state_nxt = S_MARK;
        end else if (idx_last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + XW'(1);
          state_nxt = S_CMP_RD;
        end
      end
      S_MARK: begin
        st_we     = 1'b1;
        st_waddr  = SAW'(cur_r);
        st_wdata  = wlrs_pkg::BYTE_ERASED;
        saved_nxt = 1'b1;
        idx_nxt   = '0;
        cur_nxt   = (next_a >= end_r || !fits_next) ? start_r : next_a;
        state_nxt = S_CP_RD;
      end
      S_CP_RD: begin
        sg_re     = 1'b1;
        state_nxt = S_CP_WT;
      end
      S_CP_WT: begin
        st_we = 1'b1;
        if (idx_last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + XW'(1);
          state_nxt = S_CP_RD;
        end
      end
      S_LD_RD: begin
        // read only once the output register can take the byte
        if (out_free) begin
          st_re     = 1'b1;
          state_nxt = S_LD_WT;
        end
      end
      S_LD_WT: begin
        load_out      = 1'b1;
        out_byte_nxt  = old_b;
        out_found_nxt = 1'b1;
        out_saved_nxt = 1'b0;
        out_last_nxt  = idx_last;
        if (idx_last) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + XW'(1);
          state_nxt = S_LD_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_byte_nxt  = '0;
          out_found_nxt = found_r;
          out_saved_nxt = saved_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ch.ready) || load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      op_save_r   <= 1'b0;
      found_r     <= 1'b0;
      saved_r     <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_save_r   <= op_save_nxt;
      found_r     <= found_nxt;
      saved_r     <= saved_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    sz_r        <= sz_nxt;
    out_byte_r  <= out_byte_nxt;
    out_found_r <= out_found_nxt;
    out_saved_r <= out_saved_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result loaded while output register still full");

  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(cnt_r) < XW'(MAX_RECORD_BYTES))
    else $error("staged count reached staging depth");

  a_no_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD_RD || state_r == S_LD_WT || state_r == S_SCAN_RD ||
     state_r == S_SCAN_WT) |-> !st_we)
    else $error("store written during scan or load");

  a_store_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_we || st_re) |-> (PW'(st_we ? st_waddr : st_raddr) < STORE_LIM))
    else $error("store access beyond store end");

  a_last_save_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.action == wlrs_pkg::ACT_SAVE && cnt_nxt == '0) |=>
      (state_r == S_SETUP))
    else $error("completed record did not start a save");

endmodule

`default_nettype wire

// File: rtl/core/wear_leveled_record_store.sv
// Wear-leveled record store: a ring of fixed-size record slots in a byte
// store that is erased to 0xFF; the current record is the first slot whose
// byte 0 has bit 7 clear.
// Channels: in_ch takes items {action, data_byte}; a load item (action 0)
// returns record_size items, byte 0 with bit 7 cleared, or one not-found
// item. Save items carry a record byte by byte; the last byte yields one
// item telling whether a current record was found and whether a write
// happened. out_ch carries {out_byte, found, saved, last_of_run}.
// Configuration: cfg_we / cfg_idx / cfg_wdata write region_start,
// record_size and record_slots; write only while the block is idle.
// Timing: a save byte that is not the last is taken in one cycle. Every
// other item costs 2 setup cycles, 2 per slot looked at by the scan (one
// store read each) and 1 to pick the slot (2 if the scan runs off the ring),
// then 2 per byte loaded, or 2 per byte compared plus 1 + 2*record_size when
// a new record is written, plus 1 to post a save or not-found result. The
// one-cycle registered store read sets these figures.
// Reset: the store is erased by a pass of STORE_BYTES cycles, one byte a
// cycle, during which in_ch.ready is low; config writes are taken as ever.
// A stalled receiver holds the result in the output register; a load then
// waits, and a new item is taken once the final result is registered.
`default_nettype none

module wear_leveled_record_store #(
  parameter int STORE_BYTES      = wlrs_pkg::DEF_STORE_BYTES,
  parameter int MAX_RECORD_BYTES = wlrs_pkg::DEF_MAX_RECORD_BYTES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  wlrs_in_if.sink                                in_ch,
  wlrs_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [wlrs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [wlrs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SAW = $clog2(STORE_BYTES);
  localparam int IW  = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

  logic [wlrs_pkg::START_W-1:0] region_start_r;
  logic [wlrs_pkg::SIZE_W-1:0]  record_size_r;
  logic [wlrs_pkg::SLOTS_W-1:0] record_slots_r;
  wlrs_pkg::wlrs_cfg_t          cfg_eff;

  logic           st_we, st_re, sg_we, sg_re;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [IW-1:0]  sg_waddr, sg_raddr;
  logic [7:0]     st_wdata, st_rdata, sg_wdata, sg_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= wlrs_pkg::RST_REGION_START;
      record_size_r  <= wlrs_pkg::RST_RECORD_SIZE;
      record_slots_r <= wlrs_pkg::RST_RECORD_SLOTS;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        wlrs_pkg::CFG_REGION_START: begin
          region_start_r <= cfg_wdata[wlrs_pkg::START_W-1:0];
        end
        wlrs_pkg::CFG_RECORD_SIZE: begin
          record_size_r <= cfg_wdata[wlrs_pkg::SIZE_W-1:0];
        end
        wlrs_pkg::CFG_RECORD_SLOTS: begin
          record_slots_r <= cfg_wdata[wlrs_pkg::SLOTS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // clamp size to [1, MAX_RECORD_BYTES] and slots to at least 1
  always_comb begin
    cfg_eff.region_start = region_start_r;
    if (record_size_r == '0) begin
      cfg_eff.record_size = wlrs_pkg::SIZE_W'(1);
    end else if (9'(record_size_r) > 9'(MAX_RECORD_BYTES)) begin
      cfg_eff.record_size = wlrs_pkg::SIZE_W'(MAX_RECORD_BYTES);
    end else begin
      cfg_eff.record_size = record_size_r;
    end
    cfg_eff.record_slots = (record_slots_r == '0) ? wlrs_pkg::SLOTS_W'(1) : record_slots_r;
  end

  wlrs_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  wlrs_ram #(
    .WIDTH (8),
    .DEPTH (MAX_RECORD_BYTES)
  ) u_staging (
    .clk   (clk),
    .we    (sg_we),
    .waddr (sg_waddr),
    .wdata (sg_wdata),
    .re    (sg_re),
    .raddr (sg_raddr),
    .rdata (sg_rdata)
  );

  wlrs_ctrl #(
    .STORE_BYTES      (STORE_BYTES),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_eff),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .st_we    (st_we),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .st_re    (st_re),
    .st_raddr (st_raddr),
    .st_rdata (st_rdata),
    .sg_we    (sg_we),
    .sg_waddr (sg_waddr),
    .sg_wdata (sg_wdata),
    .sg_re    (sg_re),
    .sg_raddr (sg_raddr),
    .sg_rdata (sg_rdata)
  );

endmodule

`default_nettype wire
